// File: hdl/ssds_pkg.sv
// Shared types, constants and the segment decode function of the display scanner.
// No dependencies; used by ssds_div and seven_segment_radix_display_scanner_unit.
package ssds_pkg;

    // field and register widths
    localparam int DATA_W     = 32;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 8;
    localparam int DSEL_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // one quotient bit per step of the divider
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // radix register limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // register index (word address bits of paddr)
    localparam logic [APB_ADDR_W-3:0] REG_RADIX = '0;

    // command codes carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // load sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BUSY
    } ssds_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // digit value to segment code, bit0 = a through bit6 = g
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'h0:    code = 8'h3f;
            4'h1:    code = 8'h06;
            4'h2:    code = 8'h5b;
            4'h3:    code = 8'h4f;
            4'h4:    code = 8'h66;
            4'h5:    code = 8'h6d;
            4'h6:    code = 8'h7d;
            4'h7:    code = 8'h07;
            4'h8:    code = 8'h7f;
            4'h9:    code = 8'h6f;
            4'ha:    code = 8'h77;
            4'hb:    code = 8'h7c;
            4'hc:    code = 8'h39;
            4'hd:    code = 8'h5e;
            4'he:    code = 8'h79;
            4'hf:    code = 8'h71;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/ssds_div.sv
// Shared restoring divider: 32-bit dividend by a radix of at most 16, one bit per cycle.
// Depends on ssds_pkg.
module ssds_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ssds_pkg::DATA_W-1:0]         dividend,
    input  logic [ssds_pkg::RADIX_W-1:0]        divisor,
    output ssds_pkg::div_status_t               div_stat,
    output logic [ssds_pkg::DATA_W-1:0]         quotient,
    output logic [ssds_pkg::DIGIT_W-1:0]        remainder
);
    import ssds_pkg::*;

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [DIGIT_W:0]     trial;
    logic                 fits;

    // one shift-compare-subtract step
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = (trial >= divisor);

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next    = dividend;
            rem_next    = '0;
        end else if (active_reg) begin
            quo_next = {quo_reg[DATA_W-2:0], fits};
            rem_next = fits ? DIGIT_W'(trial - divisor) : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign div_stat.busy = active_reg;
    assign div_stat.done = done_reg;
    assign quotient      = quo_reg;
    assign remainder     = rem_reg;

endmodule

// File: hdl/seven_segment_radix_display_scanner_unit.sv
// Top level of the multiplexed seven-segment display scanner.
// Depends on ssds_pkg and ssds_div.
//
// A load transfer (s_tuser = 0) splits the 32-bit number into NUM_DIGITS digits in the
// base held in the radix register (clamped to 2..16) and stores their segment codes;
// leading zero digits are blanked and the lowest digit always shows. Each digit comes
// from one pass of the shared bit-serial divider, so a load keeps s_tready low until
// all NUM_DIGITS segment codes are stored, and gives no result. A scan transfer
// (s_tuser = 1) places the active-low digit select and segment byte of the current
// position in the output register, then steps the position modulo NUM_DIGITS; it is
// taken whenever no load is in progress and the output register is empty or being
// drained. The radix register resets to 10 and the segment buffer to blank.
module seven_segment_radix_display_scanner_unit #(
    parameter int NUM_DIGITS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssds_pkg::DATA_W-1:0]         s_tdata,   // [31:0] number
    input  logic                                s_tuser,   // [0] cmd
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ssds_pkg::DSEL_W+ssds_pkg::SEG_W-1:0] m_tdata, // [7:0] digit_select,
                                                                 // [15:8] segments
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssds_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ssds_pkg::*;

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    ssds_state_t          state_reg, state_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_eff;
    logic [SEG_W-1:0]     seg_buf_reg [NUM_DIGITS];
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     pos_rev;
    logic [POS_W-1:0]     k_reg, k_next;
    logic [DATA_W-1:0]    rest_reg;
    logic                 m_valid_reg;
    logic [DSEL_W+SEG_W-1:0] m_data_reg;
    logic [DSEL_W-1:0]    dsel;
    logic                 s_fire, load_fire, scan_fire, m_fire;
    logic                 div_start;
    logic                 digit_wr;
    logic [SEG_W-1:0]     digit_code;
    logic                 cfg_wr;
    div_status_t          div_stat;
    logic [DATA_W-1:0]    div_quo;
    logic [DIGIT_W-1:0]   div_rem;

    // handshakes
    assign s_fire    = s_tvalid & s_tready;
    assign load_fire = s_fire & (s_tuser == CMD_LOAD);
    assign scan_fire = s_fire & (s_tuser == CMD_SCAN);
    assign m_fire    = m_valid_reg & m_tready;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready
                    & (paddr[APB_ADDR_W-1:2] == REG_RADIX);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_RADIX)
                    ? APB_DATA_W'(radix_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    // out-of-range radix is clamped
    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // shared divider
    ssds_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rest_reg),
        .divisor   (radix_eff),
        .div_stat  (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load_fire) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_BUSY;
            end
            ST_BUSY: begin
                if (div_stat.done) begin
                    state_next = (k_reg == POS_LAST) ? ST_IDLE : ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        digit_wr  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = ~m_valid_reg | m_tready;
            end
            ST_START: begin
                div_start = 1'b1;
            end
            ST_BUSY: begin
                digit_wr = div_stat.done;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // digit index and running quotient
    always_comb begin
        k_next = k_reg;
        if (load_fire) begin
            k_next = '0;
        end else if (digit_wr) begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire) begin
            rest_reg <= s_tdata;
        end else if (digit_wr) begin
            rest_reg <= div_quo;
        end
    end

    // leading zero blanking, lowest digit always shown
    assign digit_code = ((k_reg == '0) || (rest_reg != '0)) ? seg_decode(div_rem) : '0;

    // segment buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                seg_buf_reg[i] <= '0;
            end
        end else if (digit_wr) begin
            seg_buf_reg[k_reg] <= digit_code;
        end
    end

    // scan position
    always_comb begin
        pos_next = pos_reg;
        if (scan_fire) begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // active-low select, position 0 (lowest digit) drives bit NUM_DIGITS-1
    assign pos_rev = POS_LAST - pos_reg;
    always_comb begin
        for (int i = 0; i < DSEL_W; i++) begin
            dsel[i] = !(4'(pos_rev) == 4'(i));
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (scan_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_fire) begin
            m_data_reg <= {seg_buf_reg[pos_reg], dsel};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("scan position out of range");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_BUSY))
        else $error("divider done outside busy state");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> (state_reg == ST_START) && !s_tready)
        else $error("load transfer did not start the digit sequence");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_fire |=> m_tvalid
            && (pos_reg == (($past(pos_reg) == POS_LAST) ? '0 : $past(pos_reg) + 1'b1)))
        else $error("scan transfer did not step the position");

endmodule
